// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/wpc_pkg.sv =====
// ----------------------------------------------------------------------------
// wpc_pkg
// Constants, types and helpers shared by the window peak counter.
// ----------------------------------------------------------------------------
package wpc_pkg;

  localparam int unsigned MAX_WINDOW = 4096;
  localparam int unsigned MAX_LEN    = 1048576;
  localparam int unsigned MIN_WINDOW = 3;
  localparam int unsigned RING_AW    = $clog2(MAX_WINDOW);
  localparam int unsigned POS_W      = $clog2(MAX_LEN);
  localparam int unsigned IDX_W      = POS_W + 1;
  localparam int unsigned LEN_W      = 13;
  localparam int unsigned CNT_W      = 12;
  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned START_W    = 21;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [LEN_W-1:0]           len_t;
  typedef logic [CNT_W-1:0]           cnt_t;
  typedef logic [IDX_W-1:0]           idx_t;
  typedef logic [POS_W-1:0]           pos_t;
  typedef logic [RING_AW-1:0]         ring_addr_t;
  typedef logic [START_W-1:0]         start_t;

  typedef struct packed {
    logic       last;
    logic       act;
    logic       wr_en;
    logic       pk;
    ring_addr_t waddr;
    logic       past;
    logic       first_full;
    pos_t       start;
    logic       too_short;
  } wpc_stage_t;

  function automatic len_t clamp_len(input len_t w);
    len_t r;
    if (w < LEN_W'(MIN_WINDOW)) begin
      r = LEN_W'(MIN_WINDOW);
    end else if (w > LEN_W'(MAX_WINDOW)) begin
      r = LEN_W'(MAX_WINDOW);
    end else begin
      r = w;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/wpc_if.sv =====
// ----------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels for samples in and results out.
// ----------------------------------------------------------------------------
interface wpc_in_if;
  import wpc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

interface wpc_out_if;
  import wpc_pkg::*;

  logic         valid;
  logic         ready;
  cnt_t         parts;
  start_t       start_position;
  logic         too_short;

  modport source (output valid, output parts, output start_position, output too_short,
                  input ready);
  modport sink (input valid, input parts, input start_position, input too_short,
                output ready);
endinterface

// ===== hw/rtl/window_peak_count_argmax_top.sv =====
// ----------------------------------------------------------------------------
// window_peak_count_argmax_top
// Sliding-window local maxima counter with best-window search.
// ----------------------------------------------------------------------------
// Samples arrive on the samples channel, one signed value per transaction,
// with last set on the final sample of a sequence. A sample is a peak when it
// is strictly greater than both neighbors. The block reports, per sequence,
// the largest number of peaks inside any window plus one, the 1-based start
// of the earliest such window, and too_short when the sequence was shorter
// than the window. cfg_wr_en/cfg_wr_data set the window length; it is latched
// at the first sample of each sequence and clamped to 3..4096. One sample is
// taken every cycle while not stalled. The peak flags live in a 4096-entry
// ring memory read ahead of the count update, with forwarding from the write
// port. A result becomes valid on the results channel once its last sample
// has passed the s1 and result registers. If the receiver stalls, samples keep
// flowing until a second last sample reaches the count stage, which then holds
// until the waiting result is taken. Reset clears the sequence state and the
// window length returns to 3; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module window_peak_count_argmax_top (
  input  logic          clk,
  input  logic          rst,
  wpc_in_if.sink        samples,
  wpc_out_if.source     results,
  input  logic          cfg_wr_en,
  input  wpc_pkg::len_t cfg_wr_data
);
  import wpc_pkg::*;

  logic       stall;
  logic       ring_ren;
  ring_addr_t ring_raddr;
  logic       ring_we;
  ring_addr_t ring_waddr;
  logic       ring_wdata;
  logic       ring_rdata;
  logic       s1_valid;
  wpc_stage_t s1;

  wpc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .samples     (samples),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .stall       (stall),
    .ring_ren    (ring_ren),
    .ring_raddr  (ring_raddr),
    .s1_valid    (s1_valid),
    .s1          (s1)
  );

  wpc_ring u_ring (
    .clk   (clk),
    .ren   (ring_ren),
    .raddr (ring_raddr),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .rdata (ring_rdata)
  );

  wpc_tally u_tally (
    .clk        (clk),
    .rst        (rst),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .ring_rdata (ring_rdata),
    .stall      (stall),
    .ring_we    (ring_we),
    .ring_waddr (ring_waddr),
    .ring_wdata (ring_wdata),
    .results    (results)
  );
endmodule

// ===== hw/rtl/wpc_ring.sv =====
// ----------------------------------------------------------------------------
// wpc_ring
// Peak flag ring memory with a registered read and write-to-read forwarding.
// ----------------------------------------------------------------------------
module wpc_ring (
  input  logic                clk,
  input  logic                ren,
  input  wpc_pkg::ring_addr_t raddr,
  input  logic                we,
  input  wpc_pkg::ring_addr_t waddr,
  input  logic                wdata,
  output logic                rdata
);
  import wpc_pkg::*;

  logic mem [MAX_WINDOW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end
endmodule

// ===== hw/rtl/wpc_front.sv =====
// ----------------------------------------------------------------------------
// wpc_front
// Input stage: sample index, neighbor history, peak test and ring addressing.
// ----------------------------------------------------------------------------
module wpc_front (
  input  logic                clk,
  input  logic                rst,
  wpc_in_if.sink              samples,
  input  logic                cfg_wr_en,
  input  wpc_pkg::len_t       cfg_wr_data,
  input  logic                stall,
  output logic                ring_ren,
  output wpc_pkg::ring_addr_t ring_raddr,
  output logic                s1_valid,
  output wpc_pkg::wpc_stage_t s1
);
  import wpc_pkg::*;

  len_t       window_len;
  len_t       active_len;
  idx_t       sample_index;
  sample_t    prev_sample;
  sample_t    prev_prev_sample;

  logic       accept;
  logic       act;
  len_t       k;
  idx_t       k_ext;
  idx_t       idx_inc;
  idx_t       idx_dec;
  idx_t       gone;
  idx_t       seen;
  wpc_stage_t stage;

  assign samples.ready = !stall;
  assign accept        = samples.valid && samples.ready;

  always_comb begin
    act      = sample_index < IDX_W'(MAX_LEN);
    k        = (sample_index == '0) ? clamp_len(window_len) : active_len;
    k_ext    = IDX_W'(k);
    idx_inc  = sample_index + IDX_W'(1);
    idx_dec  = sample_index - IDX_W'(1);
    gone     = idx_inc - k_ext;
    seen     = act ? idx_inc : sample_index;

    stage.last       = samples.last;
    stage.act        = act;
    stage.wr_en      = act && (sample_index >= IDX_W'(2));
    stage.pk         = (prev_sample > prev_prev_sample) && (prev_sample > samples.sample);
    stage.waddr      = idx_dec[RING_AW-1:0];
    stage.past       = act && (sample_index >= k_ext);
    stage.first_full = act && (idx_inc == k_ext);
    stage.start      = gone[POS_W-1:0];
    stage.too_short  = seen < k_ext;
  end

  assign ring_ren   = accept && stage.past;
  assign ring_raddr = gone[RING_AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len       <= LEN_W'(MIN_WINDOW);
      active_len       <= LEN_W'(MIN_WINDOW);
      sample_index     <= '0;
      prev_sample      <= '0;
      prev_prev_sample <= '0;
      s1_valid         <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_len <= cfg_wr_data;
      end
      if (accept) begin
        if (samples.last) begin
          sample_index     <= '0;
          prev_sample      <= '0;
          prev_prev_sample <= '0;
        end else if (act) begin
          sample_index     <= idx_inc;
          prev_sample      <= samples.sample;
          prev_prev_sample <= prev_sample;
        end
        if (act && (sample_index == '0)) begin
          active_len <= k;
        end
      end
      if (!stall) begin
        s1_valid <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s1 <= stage;
    end
  end
endmodule

// ===== hw/rtl/wpc_tally.sv =====
// ----------------------------------------------------------------------------
// wpc_tally
// Second stage: running window count, best window tracking, result register.
// ----------------------------------------------------------------------------
module wpc_tally (
  input  logic                clk,
  input  logic                rst,
  input  logic                s1_valid,
  input  wpc_pkg::wpc_stage_t s1,
  input  logic                ring_rdata,
  output logic                stall,
  output logic                ring_we,
  output wpc_pkg::ring_addr_t ring_waddr,
  output logic                ring_wdata,
  wpc_out_if.source           results
);
  import wpc_pkg::*;

  cnt_t   window_count;
  cnt_t   best_count;
  pos_t   best_start;
  logic   out_valid;
  cnt_t   out_parts;
  start_t out_start;
  logic   out_short;

  logic   advance;
  logic   dec;
  cnt_t   cnt_mid;
  cnt_t   cnt_new;
  cnt_t   best_count_next;
  pos_t   best_start_next;

  assign stall   = s1_valid && s1.last && out_valid && !results.ready;
  assign advance = s1_valid && !stall;

  always_comb begin
    dec     = s1.past && ring_rdata && (window_count != '0);
    cnt_mid = window_count - CNT_W'(dec);
    cnt_new = cnt_mid + CNT_W'(s1.wr_en && s1.pk);
    best_count_next = best_count;
    best_start_next = best_start;
    if (s1.first_full) begin
      best_count_next = cnt_new;
      best_start_next = '0;
    end else if (s1.past && (cnt_new > best_count)) begin
      best_count_next = cnt_new;
      best_start_next = s1.start;
    end
  end

  assign ring_we    = advance && s1.wr_en;
  assign ring_waddr = s1.waddr;
  assign ring_wdata = s1.pk;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= '0;
      best_count   <= '0;
      best_start   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (advance) begin
        if (s1.last) begin
          window_count <= '0;
          best_count   <= '0;
          best_start   <= '0;
        end else if (s1.act) begin
          window_count <= cnt_new;
          best_count   <= best_count_next;
          best_start   <= best_start_next;
        end
      end
      if (advance && s1.last) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1.last) begin
      if (s1.too_short) begin
        out_parts <= CNT_W'(1);
        out_start <= START_W'(1);
        out_short <= 1'b1;
      end else begin
        out_parts <= best_count_next + CNT_W'(1);
        out_start <= START_W'(best_start_next) + START_W'(1);
        out_short <= 1'b0;
      end
    end
  end

  assign results.valid          = out_valid;
  assign results.parts          = out_parts;
  assign results.start_position = out_start;
  assign results.too_short      = out_short;
endmodule

// ===== hw/rtl/wpc_checker.sv =====
// ----------------------------------------------------------------------------
// wpc_checker
// Port-level checks on the window peak counter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wpc_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input wpc_pkg::cnt_t    parts,
  input wpc_pkg::start_t  start_position,
  input logic             too_short
);
  import wpc_pkg::*;

  logic hold;
  logic short_ok;

  assign hold     = out_valid && !out_ready;
  assign short_ok = (parts == CNT_W'(1)) && (start_position == START_W'(1));

  `ASSERT_NEXT(a_out_hold, clk, rst, hold, out_valid)
  `ASSERT_NEXT(a_out_stable, clk, rst, hold, $stable({parts, start_position, too_short}))
  `ASSERT_IMPLIES(a_short_result, clk, rst, out_valid && too_short, short_ok)
  `ASSERT_IMPLIES(a_nonzero_result, clk, rst, out_valid, (parts != '0) && (start_position != '0))
  `ASSERT_IMPLIES(a_ready_when_empty, clk, rst, !out_valid, in_ready)
endmodule

bind window_peak_count_argmax_top wpc_checker u_wpc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (samples.ready),
  .out_valid      (results.valid),
  .out_ready      (results.ready),
  .parts          (results.parts),
  .start_position (results.start_position),
  .too_short      (results.too_short)
);
